[src/cfdr_pkg.sv]
// cfdr_pkg: shared types, constants and the CRC-8 step for the start-byte frame deframer.
// No dependencies; used by cfdr_front, cfdr_back and crc8_frame_deframer_resync.
package cfdr_pkg;

	localparam int FRAME_LEN = 11;
	localparam int NUM_PAYLOAD = FRAME_LEN - 2;
	localparam int IDX_W = $clog2(FRAME_LEN + 1);

	localparam logic [7:0] START_BYTE = 8'hDD;
	localparam logic [7:0] CRC_INIT = 8'h00;
	localparam logic [7:0] CRC_POLY = 8'h07;

	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t LAST_FILL = idx_t'(FRAME_LEN - 1);
	localparam idx_t FIRST_CRC_IDX = idx_t'(1);
	localparam idx_t LAST_CRC_IDX = idx_t'(FRAME_LEN - 2);

	typedef enum logic [1:0] {
		STATUS_GOOD = 2'd0,
		STATUS_RESYNC = 2'd1,
		STATUS_DISCARD = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_CHECK,
		ST_SHIFT
	} back_state_t;

	// one received byte, tagged by the front end
	typedef struct packed {
		logic [7:0] data;
		logic is_start;
	} rx_item_t;

	// head of the queue as seen by the back end
	typedef struct packed {
		logic valid;
		rx_item_t item;
	} q_head_t;

	// CRC-8, MSB first, one byte folded in
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[src/cfdr_front.sv]
// cfdr_front: input beat acceptance, start-byte tagging and a two-entry queue.
// Depends on cfdr_pkg.
module cfdr_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] rx_byte,
	output cfdr_pkg::q_head_t q_head,
	input  logic q_pop
);

	cfdr_pkg::rx_item_t mem_q [0:1];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic push;
	cfdr_pkg::rx_item_t new_item;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;

	always_comb begin
		new_item.data = rx_byte;
		new_item.is_start = (rx_byte == cfdr_pkg::START_BYTE);
	end

	assign q_head.valid = (cnt_q != 2'd0);
	assign q_head.item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, q_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[src/cfdr_back.sv]
// cfdr_back: frame window, sequential CRC check, resync shifter and result register.
// Depends on cfdr_pkg; fed by cfdr_front.
module cfdr_back (
	input  logic clk,
	input  logic arst_n,
	input  cfdr_pkg::q_head_t q_head,
	output logic q_pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] frame_status,
	output logic [7:0] payload [0:cfdr_pkg::NUM_PAYLOAD-1]
);

	cfdr_pkg::back_state_t state_q, state_nxt;
	logic [7:0] window_q [0:cfdr_pkg::FRAME_LEN-1];
	logic [cfdr_pkg::FRAME_LEN-1:0] start_q;
	cfdr_pkg::idx_t fill_q;
	cfdr_pkg::idx_t idx_q;
	logic [7:0] crc_q;
	logic [7:0] crc_nxt;
	logic out_valid_q;
	logic [1:0] status_q;
	logic [7:0] pl_q [0:cfdr_pkg::NUM_PAYLOAD-1];

	logic out_free;
	logic crc_last;
	logic emit;
	logic good;
	logic any_start;
	logic fill_done;

	assign out_free = !out_valid_q || !out_stall;
	assign crc_nxt = cfdr_pkg::crc8_byte(crc_q, window_q[idx_q]);
	assign crc_last = (idx_q == cfdr_pkg::LAST_CRC_IDX);
	assign good = start_q[0] && (crc_nxt == window_q[cfdr_pkg::FRAME_LEN-1]);
	assign any_start = |start_q[cfdr_pkg::FRAME_LEN-1:1];
	assign fill_done = (fill_q == cfdr_pkg::LAST_FILL);

	// control outputs
	always_comb begin
		q_pop = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			cfdr_pkg::ST_COLLECT: q_pop = q_head.valid;
			cfdr_pkg::ST_CHECK: emit = crc_last && out_free;
			cfdr_pkg::ST_SHIFT: ;
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			cfdr_pkg::ST_COLLECT: begin
				if (q_pop && fill_done) begin
					state_nxt = cfdr_pkg::ST_CHECK;
				end
			end
			cfdr_pkg::ST_CHECK: begin
				if (emit) begin
					state_nxt = (!good && any_start) ? cfdr_pkg::ST_SHIFT : cfdr_pkg::ST_COLLECT;
				end
			end
			cfdr_pkg::ST_SHIFT: begin
				// stop once the byte moving into slot 0 is a start byte
				if (start_q[1]) begin
					state_nxt = cfdr_pkg::ST_COLLECT;
				end
			end
			default: state_nxt = cfdr_pkg::ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfdr_pkg::ST_COLLECT;
			fill_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				cfdr_pkg::ST_COLLECT: begin
					if (q_pop) begin
						fill_q <= fill_q + cfdr_pkg::idx_t'(1);
						idx_q <= cfdr_pkg::FIRST_CRC_IDX;
					end
				end
				cfdr_pkg::ST_CHECK: begin
					if (!crc_last) begin
						idx_q <= idx_q + cfdr_pkg::idx_t'(1);
					end else if (emit && (good || !any_start)) begin
						fill_q <= '0;
					end
				end
				cfdr_pkg::ST_SHIFT: fill_q <= fill_q - cfdr_pkg::idx_t'(1);
				default: ;
			endcase
		end
	end

	// window, CRC accumulator and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			cfdr_pkg::ST_COLLECT: begin
				if (q_pop) begin
					window_q[fill_q] <= q_head.item.data;
					start_q[fill_q] <= q_head.item.is_start;
					crc_q <= cfdr_pkg::CRC_INIT;
				end
			end
			cfdr_pkg::ST_CHECK: begin
				if (!crc_last) begin
					crc_q <= crc_nxt;
				end
			end
			cfdr_pkg::ST_SHIFT: begin
				for (int k = 0; k < cfdr_pkg::FRAME_LEN - 1; k++) begin
					window_q[k] <= window_q[k+1];
					start_q[k] <= start_q[k+1];
				end
			end
			default: ;
		endcase
		if (emit) begin
			if (good) begin
				status_q <= cfdr_pkg::STATUS_GOOD;
			end else if (any_start) begin
				status_q <= cfdr_pkg::STATUS_RESYNC;
			end else begin
				status_q <= cfdr_pkg::STATUS_DISCARD;
			end
			for (int k = 0; k < cfdr_pkg::NUM_PAYLOAD; k++) begin
				pl_q[k] <= good ? window_q[k+1] : 8'h00;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign frame_status = status_q;
	assign payload = pl_q;

endmodule

[src/crc8_frame_deframer_resync.sv]
// crc8_frame_deframer_resync: top level of the start-byte CRC-8 frame deframer.
// Depends on cfdr_pkg, cfdr_front and cfdr_back.
//
//   channel | direction | handshake            | beat contents
//   --------+-----------+----------------------+-------------------------------------
//   input   | in        | in_valid / in_stall  | rx_byte
//   output  | out       | out_valid / out_stall| frame_status, payload_1 .. payload_9
//
// A byte is taken each cycle while the two-entry queue has room; the back end
// moves one byte a cycle into the window while it collects and the queue
// holds a byte. When the eleventh byte lands, the CRC over bytes 1 to 9 is
// folded in one byte a cycle, the last one waiting for a free result
// register; then a resync, if one is due, drops one byte a cycle until the
// next start byte reaches slot 0.
// Reset clears the queue, the fill count, the state and the result valid; the
// window itself is not cleared. A stalled result holds the back end at the
// end of its check, and the queue then fills and stalls the input.
module crc8_frame_deframer_resync (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] rx_byte,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] frame_status,
	output logic [7:0] payload_1,
	output logic [7:0] payload_2,
	output logic [7:0] payload_3,
	output logic [7:0] payload_4,
	output logic [7:0] payload_5,
	output logic [7:0] payload_6,
	output logic [7:0] payload_7,
	output logic [7:0] payload_8,
	output logic [7:0] payload_9
);

	// queue head from front to back, and the pop back
	cfdr_pkg::q_head_t q_head;
	logic q_pop;
	logic [7:0] payload [0:cfdr_pkg::NUM_PAYLOAD-1];

	// front: accept, tag start bytes, buffer
	cfdr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.q_head   (q_head),
		.q_pop    (q_pop)
	);

	// back: window, check, resync, result register
	cfdr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_status (frame_status),
		.payload      (payload)
	);

	assign payload_1 = payload[0];
	assign payload_2 = payload[1];
	assign payload_3 = payload[2];
	assign payload_4 = payload[3];
	assign payload_5 = payload[4];
	assign payload_6 = payload[5];
	assign payload_7 = payload[6];
	assign payload_8 = payload[7];
	assign payload_9 = payload[8];

endmodule

[verif/deframe_monitor.sv]
// deframe_monitor: watches both channels of the frame deframer, predicts each frame verdict
// and compares it with what comes out. Depends on cfdr_pkg (status codes, start byte).
// Also holds deframe_tb_pkg, the CRC helper shared with the stimulus in the testbench top.
package deframe_tb_pkg;

	import cfdr_pkg::*;

	// CRC-8 over payload bytes 1..9, bit-serial form, byte k at index k-1
	function automatic logic [7:0] crc8_nine(input logic [8:0][7:0] pay);
		logic [7:0] crc;
		logic fb;
		crc = CRC_INIT;
		for (int k = 0; k < 9; k++) begin
			for (int i = 7; i >= 0; i--) begin
				fb = crc[7] ^ pay[k][i];
				crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
			end
		end
		return crc;
	endfunction

endpackage

module deframe_monitor
	import cfdr_pkg::*;
	import deframe_tb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic [7:0] rx_byte,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [1:0] frame_status,
	input  logic [7:0] payload_1,
	input  logic [7:0] payload_2,
	input  logic [7:0] payload_3,
	input  logic [7:0] payload_4,
	input  logic [7:0] payload_5,
	input  logic [7:0] payload_6,
	input  logic [7:0] payload_7,
	input  logic [7:0] payload_8,
	input  logic [7:0] payload_9,
	output int mismatches,
	output int frames_owed
);

	typedef struct packed {
		status_t status;
		logic [8:0][7:0] pay;
	} frame_verdict_t;

	logic [7:0] win [0:10];
	logic [3:0] fill;
	frame_verdict_t frames_due [$];
	int errs;

	// one accepted byte into the window; a full window yields one verdict
	task automatic window_take_byte(input logic [7:0] b);
		frame_verdict_t v;
		logic [8:0][7:0] body;
		int pos;
		if (fill > 4'd10) fill = 4'd10;
		win[fill] = b;
		fill = fill + 4'd1;
		if (fill != 4'd11) return;
		v = '0;
		for (int k = 0; k < 9; k++) body[k] = win[k+1];
		if (win[0] == START_BYTE && win[10] == crc8_nine(body)) begin
			v.status = STATUS_GOOD;
			v.pay = body;
			fill = 4'd0;
		end else begin
			pos = 11;
			for (int k = 10; k >= 1; k--) begin
				if (win[k] == START_BYTE) pos = k;
			end
			if (pos == 11) begin
				v.status = STATUS_DISCARD;
				fill = 4'd0;
			end else begin
				v.status = STATUS_RESYNC;
				for (int k = 0; k < 11 - pos; k++) win[k] = win[k+pos];
				fill = 4'(11 - pos);
			end
		end
		frames_due.push_back(v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_verdict_t want;
		logic [8:0][7:0] got;
		if (!arst_n) begin
			fill = 4'd0;
			frames_due.delete();
			errs = 0;
			mismatches <= 0;
			frames_owed <= 0;
		end else begin
			if (in_valid && !in_stall) window_take_byte(rx_byte);
			if (out_valid && !out_stall) begin
				got = {payload_9, payload_8, payload_7, payload_6, payload_5,
					payload_4, payload_3, payload_2, payload_1};
				if (frames_due.size() == 0) begin
					errs++;
					$error("frame_status: expected none, got %0d", frame_status);
				end else begin
					want = frames_due.pop_front();
					if (frame_status !== want.status) begin
						errs++;
						$error("frame_status: expected %0d, got %0d", want.status, frame_status);
					end
					for (int k = 0; k < 9; k++) begin
						if (got[k] !== want.pay[k]) begin
							errs++;
							$error("payload_%0d: expected %0h, got %0h", k + 1,
								want.pay[k], got[k]);
						end
					end
				end
			end
			mismatches <= errs;
			frames_owed <= frames_due.size();
		end
	end

endmodule

[verif/tb_crc8_frame_deframer_resync.sv]
// tb_crc8_frame_deframer_resync: byte stimulus, back-pressure and verdict for the deframer.
// Depends on the top, cfdr_pkg, deframe_tb_pkg and deframe_monitor, which does all the checking.
module tb_crc8_frame_deframer_resync;

	import cfdr_pkg::*;
	import deframe_tb_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] rx_byte;
	logic out_valid;
	logic out_stall;
	logic [1:0] frame_status;
	logic [7:0] payload_1, payload_2, payload_3, payload_4, payload_5;
	logic [7:0] payload_6, payload_7, payload_8, payload_9;
	int mismatches;
	int frames_owed;

	// whole byte stream, built before the first beat goes out
	logic [7:0] line_bytes [$];

	crc8_frame_deframer_resync u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall), .frame_status(frame_status),
		.payload_1(payload_1), .payload_2(payload_2), .payload_3(payload_3),
		.payload_4(payload_4), .payload_5(payload_5), .payload_6(payload_6),
		.payload_7(payload_7), .payload_8(payload_8), .payload_9(payload_9)
	);

	deframe_monitor u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall), .frame_status(frame_status),
		.payload_1(payload_1), .payload_2(payload_2), .payload_3(payload_3),
		.payload_4(payload_4), .payload_5(payload_5), .payload_6(payload_6),
		.payload_7(payload_7), .payload_8(payload_8), .payload_9(payload_9),
		.mismatches(mismatches), .frames_owed(frames_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Worst case is about one verdict per byte (resync at slot 1), each costing
	// the CRC pass plus the shift, stretched by back-pressure; the timeout
	// leaves plenty of margin over that.
	initial begin
		#2000000;
		$display("crc8_frame_deframer_resync verification failed");
		$finish;
	end

	// payload byte with extra weight on the start byte and the two extremes
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 10) return START_BYTE;
		if (r < 15) return 8'h00;
		if (r < 20) return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	// queue one frame: start byte, nine payload bytes, CRC
	task automatic push_frame(input logic [8:0][7:0] pay, input logic [7:0] crc);
		line_bytes.push_back(START_BYTE);
		for (int k = 0; k < 9; k++) line_bytes.push_back(pay[k]);
		line_bytes.push_back(crc);
	endtask

	initial begin
		logic [8:0][7:0] pay;
		logic [7:0] crc;
		int kind;
		int n;
		int sent;
		int base;
		bit calm;

		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		out_stall = 1'b0;

		// --- directed part ---
		// good frame, all-zero payload (CRC of zeros is zero)
		pay = '0;
		push_frame(pay, crc8_nine(pay));
		// all-ones payload with a start byte in the CRC slot: unless the CRC
		// happens to be 0xDD this resyncs at the very last slot, fill becomes 1
		pay = '1;
		push_frame(pay, START_BYTE);
		// ten more bytes with no start byte behind the kept one: bad CRC and
		// nothing to resync on, so the window is discarded
		for (int k = 0; k < 10; k++) line_bytes.push_back(8'h11);
		// resync at slot 1: two start bytes in a row, then a good frame
		line_bytes.push_back(START_BYTE);
		for (int k = 0; k < 9; k++) pay[k] = 8'(k * 37 + 1);
		push_frame(pay, crc8_nine(pay));

		// --- random part: mostly framed traffic, some damage and noise ---
		while (line_bytes.size() < 1300) begin
			kind = $urandom_range(99);
			if (kind < 85) begin
				for (int k = 0; k < 9; k++) pay[k] = pick_byte();
				crc = crc8_nine(pay);
				base = line_bytes.size();
				push_frame(pay, crc);
				if (kind >= 60 && kind < 75) begin
					// corrupt one byte of the frame just queued
					n = $urandom_range(10);
					line_bytes[base+n] = line_bytes[base+n] ^ 8'($urandom_range(255, 1));
				end else if (kind >= 75) begin
					// truncated frame: drop a random tail
					n = $urandom_range(10, 1);
					repeat (n) void'(line_bytes.pop_back());
				end
			end else begin
				// line noise between frames
				n = $urandom_range(15, 1);
				repeat (n) line_bytes.push_back(pick_byte());
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Each pass samples the beat that just crossed the edge, then sets up
		// the next one. A stalled beat is held untouched; otherwise the sender
		// idles at random. Bytes 500..799 go with no idling on either side.
		sent = 0;
		while (!(sent == line_bytes.size() && frames_owed == 0 && !in_valid)) begin
			@(posedge clk);
			if (in_valid && !in_stall) sent++;
			calm = (sent >= 500 && sent < 800);
			out_stall <= !calm && ($urandom_range(99) < 36);
			if (in_valid && in_stall) begin
				// hold the stalled beat
			end else if (sent < line_bytes.size() && (calm || $urandom_range(99) >= 36)) begin
				in_valid <= 1'b1;
				rx_byte <= line_bytes[sent];
			end else begin
				in_valid <= 1'b0;
			end
		end

		// drain: a trailing partial window may still be shifting; let any
		// stray verdict show up so the monitor can flag it
		repeat (64) begin
			@(posedge clk);
			out_stall <= 1'b0;
		end
		if (mismatches == 0 && frames_owed == 0) begin
			$display("crc8_frame_deframer_resync verification clean");
		end else begin
			$display("crc8_frame_deframer_resync verification failed");
		end
		$finish;
	end

endmodule
